### rtl/gthr_pkg.sv
// ----------------------------------------------------------------------------
// gthr_pkg: shared types for the group event throttle
// Item layouts for the request/tick channel, the play result channel and the
// per-group state entry held in the state memory.
// ----------------------------------------------------------------------------
`default_nettype none

package gthr_pkg;

    localparam int unsigned TIME_W  = 16;
    localparam int unsigned GROUP_W = 4;
    localparam int unsigned FILE_W  = 8;
    localparam int unsigned PEND_W  = 8;

    // Input item modes
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    typedef struct packed {
        logic              mode;
        logic [GROUP_W-1:0] group;
        logic [FILE_W-1:0]  file_id;
        logic [TIME_W-1:0]  delay_ms;
        logic [TIME_W-1:0]  lifetime_ms;
        logic [TIME_W-1:0]  delta_ms;
    } t_in_item;

    typedef struct packed {
        logic [GROUP_W-1:0] play_group;
        logic [FILE_W-1:0]  play_file;
        logic               is_replay;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0] cooldown;
        logic [TIME_W-1:0] spacing;
        logic [PEND_W-1:0] pending;
    } t_entry;

endpackage

`default_nettype wire

### rtl/group_event_throttle.sv
// ----------------------------------------------------------------------------
// group_event_throttle: per-group play throttle with cooldown and queueing
// Keeps cooldown, spacing and pending count of each group in one memory and
// turns play requests and time ticks into play and replay results.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item and raise i_start while o_busy is low; the item is taken at
//   that edge. mode 0 is a play request for one group, mode 1 a time tick.
//   Results appear on o_result for exactly one cycle with o_strobe high; the
//   receiver must take them, there is no back pressure. The last result of
//   an item carries last = 1; an item may also yield no result at all.
//   Request: o_busy stays high through the read state alone (new or idle
//   group) or through the read and compare states (cooling group, where the
//   compare waits for the product of pending count and new spacing); the
//   play result, if any, appears in the cycle after the state entry is read.
//   Tick: o_busy stays high through the sweep state and the flush state. The
//   state memory is swept one entry per cycle in a read-modify-write
//   pipeline; each replay is held one slot so that the last one can be
//   flagged, so replays trail their group by up to the rest of the sweep.
//   The sweep length sets the tick rate.
//   Reset clears all valid bits in flip-flops at once; the memory itself is
//   not cleared, a group entry is written whole when the group becomes valid.
// ----------------------------------------------------------------------------
`default_nettype none

module group_event_throttle #(
    parameter int GROUPS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire gthr_pkg::t_in_item   i_item,
    output logic                      o_busy,
    output logic                      o_strobe,
    output gthr_pkg::t_out_item       o_result
);

    import gthr_pkg::*;

    localparam int AW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(GROUPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ_RD,
        S_REQ_CMP,
        S_TICK,
        S_FLUSH
    } t_state;

    t_state              r_state, n_state;
    logic [GROUPS-1:0]   r_valid, n_valid;
    logic [AW-1:0]       r_idx, n_idx;
    t_in_item            r_req, n_req;
    logic                r_have, n_have;
    logic [AW-1:0]       r_held, n_held;
    logic [TIME_W-1:0]   r_cool, n_cool;
    logic [PEND_W-1:0]   r_pend, n_pend;
    logic [PEND_W+TIME_W-1:0] r_prod, n_prod;
    logic                r_strobe, n_strobe;
    t_out_item           r_result, n_result;

    // State memory, one entry per group
    t_entry              r_mem [GROUPS];
    t_entry              r_rd_data;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [AW-1:0]       mem_ra;
    t_entry              mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // Next-state and memory control
    always_comb begin
        t_entry              ent;
        logic [TIME_W-1:0]   cool_dec;
        logic                fire;
        logic [PEND_W+TIME_W:0] wait_sum;

        ent      = r_rd_data;
        cool_dec = '0;
        fire     = 1'b0;
        wait_sum = '0;

        n_state  = r_state;
        n_valid  = r_valid;
        n_idx    = r_idx;
        n_req    = r_req;
        n_have   = r_have;
        n_held   = r_held;
        n_cool   = r_cool;
        n_pend   = r_pend;
        n_prod   = r_prod;
        n_strobe = 1'b0;
        n_result = r_result;
        mem_we   = 1'b0;
        mem_wa   = r_idx;
        mem_wd   = ent;
        mem_ra   = r_idx;

        case (r_state)
            S_IDLE: begin
                // Start the read of the addressed entry as the item is taken
                mem_ra = (i_item.mode == MODE_TICK) ? '0 : AW'(i_item.group);
                if (i_start) begin
                    n_req = i_item;
                    if (i_item.mode == MODE_TICK) begin
                        n_idx   = '0;
                        n_have  = 1'b0;
                        n_state = S_TICK;
                    end else if (32'(i_item.group) < GROUPS) begin
                        n_idx   = AW'(i_item.group);
                        n_state = S_REQ_RD;
                    end
                end
            end

            S_REQ_RD: begin
                n_cool = ent.cooldown;
                n_pend = ent.pending;
                n_prod = ent.pending * r_req.delay_ms;
                n_result.play_group = r_req.group;
                n_result.play_file  = r_req.file_id;
                n_result.is_replay  = 1'b0;
                n_result.last       = 1'b1;
                if (!r_valid[r_idx]) begin
                    // New group: write the whole entry and play now
                    n_valid[r_idx] = 1'b1;
                    mem_we   = 1'b1;
                    mem_wd   = '{cooldown: r_req.delay_ms, spacing: r_req.delay_ms,
                                 pending: '0};
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (ent.cooldown != '0) begin
                    // Cooling: decide on queueing once the product is in
                    n_state = S_REQ_CMP;
                end else begin
                    // Idle group: play only when nothing is pending
                    mem_we = 1'b1;
                    mem_wd = '{cooldown: (ent.pending == '0) ? r_req.delay_ms : ent.cooldown,
                               spacing: r_req.delay_ms, pending: ent.pending};
                    n_strobe = (ent.pending == '0);
                    n_state  = S_IDLE;
                end
            end

            S_REQ_CMP: begin
                wait_sum = (PEND_W+TIME_W+1)'(r_cool) + (PEND_W+TIME_W+1)'(r_prod);
                mem_we = 1'b1;
                mem_wd = '{cooldown: r_cool, spacing: r_req.delay_ms,
                           pending: ((wait_sum < (PEND_W+TIME_W+1)'(r_req.lifetime_ms))
                                     && (r_pend != PEND_MAX)) ? r_pend + 1'b1 : r_pend};
                n_state = S_IDLE;
            end

            S_TICK: begin
                // Age the entry read last cycle, replay if due, write it back
                cool_dec = (ent.cooldown <= r_req.delta_ms) ? '0
                         : ent.cooldown - r_req.delta_ms;
                fire   = r_valid[r_idx] && (cool_dec == '0) && (ent.pending != '0);
                mem_we = r_valid[r_idx];
                mem_wd = fire ? t_entry'{cooldown: ent.spacing, spacing: ent.spacing,
                                         pending: ent.pending - 1'b1}
                              : t_entry'{cooldown: cool_dec, spacing: ent.spacing,
                                         pending: ent.pending};
                if (fire) begin
                    // Release the held replay; it is not the last one
                    n_strobe            = r_have;
                    n_result.play_group = GROUP_W'(r_held);
                    n_result.play_file  = '0;
                    n_result.is_replay  = 1'b1;
                    n_result.last       = 1'b0;
                    n_held = r_idx;
                    n_have = 1'b1;
                end
                if (r_idx == LAST_IDX) begin
                    mem_ra  = '0;
                    n_state = S_FLUSH;
                end else begin
                    mem_ra = r_idx + 1'b1;
                end
                n_idx = r_idx + 1'b1;
            end

            S_FLUSH: begin
                // Drop out the held replay as the last result of the tick
                n_strobe            = r_have;
                n_result.play_group = GROUP_W'(r_held);
                n_result.play_file  = '0;
                n_result.is_replay  = 1'b1;
                n_result.last       = 1'b1;
                n_have  = 1'b0;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_have   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_have   <= n_have;
            r_strobe <= n_strobe;
        end
        r_idx    <= n_idx;
        r_req    <= n_req;
        r_held   <= n_held;
        r_cool   <= n_cool;
        r_pend   <= n_pend;
        r_prod   <= n_prod;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // A result only follows a cycle of work on an item
    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state != S_IDLE))
        else $error("result strobe without an item in progress");

    // An immediate play is always the only, hence last, result of its request
    a_play_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.is_replay) |-> o_result.last)
        else $error("immediate play not flagged last");

    // The state memory is only written while an item is in progress
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != S_IDLE))
        else $error("state memory written while idle");

    // The tick sweep always ends through the flush step
    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && r_idx == LAST_IDX) |=> (r_state == S_FLUSH))
        else $error("tick sweep did not end in flush");

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the group event throttle
// Drives play requests and time ticks through the start/busy handshake and
// predicts every play and replay from its own copy of the per-group state.
// Each strobed result is checked field by field against the oldest expected
// play. Tests run in turn: directed corner cases, a tick that replays all
// groups, a pending-queue fill to saturation, and random traffic.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gthr_pkg::*;

    localparam int GROUPS      = 16;
    localparam int RAND_ITEMS  = 90;
    localparam int FILL_ITEMS  = 262;
    localparam int TAIL_CYCLES = 2 * GROUPS + 8;
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_busy;
    logic      o_strobe;
    t_out_item o_result;

    // Predicted per-group throttle state
    logic              grp_valid    [GROUPS];
    logic [TIME_W-1:0] grp_cooldown [GROUPS];
    logic [TIME_W-1:0] grp_spacing  [GROUPS];
    logic [PEND_W-1:0] grp_pending  [GROUPS];

    t_out_item   expected_plays [$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    bit          idle_on     = 1'b1;

    group_event_throttle #(
        .GROUPS(GROUPS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    // Build one play result
    function automatic t_out_item make_play(input logic [GROUP_W-1:0] grp,
                                            input logic [FILE_W-1:0] file,
                                            input logic replay);
        t_out_item play;
        play.play_group = grp;
        play.play_file  = file;
        play.is_replay  = replay;
        play.last       = 1'b0;
        return play;
    endfunction

    // Work out the plays caused by one accepted item and advance the state
    task automatic predict_plays(input t_in_item it);
        t_out_item         plays [$];
        int unsigned       wait_ms;
        logic [GROUP_W-1:0] g;
        if (it.mode == MODE_REQUEST) begin
            g = it.group;
            if (!grp_valid[g]) begin
                grp_valid[g]    = 1'b1;
                grp_cooldown[g] = it.delay_ms;
                grp_spacing[g]  = it.delay_ms;
                grp_pending[g]  = '0;
                plays = {plays, make_play(g, it.file_id, 1'b0)};
            end else begin
                grp_spacing[g] = it.delay_ms;
                if (grp_cooldown[g] != '0) begin
                    // queue unless the wait reaches the lifetime or the count is full
                    wait_ms = 32'(grp_cooldown[g]) + 32'(grp_pending[g]) * 32'(it.delay_ms);
                    if (wait_ms < 32'(it.lifetime_ms) && grp_pending[g] != PEND_MAX)
                        grp_pending[g] = grp_pending[g] + 1'b1;
                end else if (grp_pending[g] == '0) begin
                    grp_cooldown[g] = it.delay_ms;
                    plays = {plays, make_play(g, it.file_id, 1'b0)};
                end
            end
        end else begin
            // sweep groups in ascending order, one replay per group at most
            for (int k = 0; k < GROUPS; k++) begin
                if (grp_valid[k]) begin
                    if (grp_cooldown[k] <= it.delta_ms)
                        grp_cooldown[k] = '0;
                    else
                        grp_cooldown[k] = grp_cooldown[k] - it.delta_ms;
                    if (grp_cooldown[k] == '0 && grp_pending[k] != '0) begin
                        grp_pending[k]  = grp_pending[k] - 1'b1;
                        grp_cooldown[k] = grp_spacing[k];
                        if (plays.size() < 16)
                            plays = {plays, make_play(GROUP_W'(k), '0, 1'b1)};
                    end
                end
            end
        end
        if (plays.size() != 0)
            plays[plays.size() - 1].last = 1'b1;
        expected_plays = {expected_plays, plays};
    endtask

    // Check each strobed result, then predict for an item taken at this edge
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_plays.size() == 0) begin
                    $error("play result with nothing expected: group %0d replay %0b",
                           o_result.play_group, o_result.is_replay);
                    mismatches++;
                end else begin
                    want = expected_plays.pop_front();
                    if (o_result.play_group !== want.play_group) begin
                        $error("play_group: expected %0d, got %0d",
                               want.play_group, o_result.play_group);
                        mismatches++;
                    end
                    if (o_result.play_file !== want.play_file) begin
                        $error("play_file: expected %0d, got %0d",
                               want.play_file, o_result.play_file);
                        mismatches++;
                    end
                    if (o_result.is_replay !== want.is_replay) begin
                        $error("is_replay: expected %0b, got %0b",
                               want.is_replay, o_result.is_replay);
                        mismatches++;
                    end
                    if (o_result.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_result.last);
                        mismatches++;
                    end
                end
            end
            if (i_start && !o_busy)
                predict_plays(i_item);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Build a play request; the tick field carries noise
    function automatic t_in_item make_request(input logic [GROUP_W-1:0] grp,
                                              input logic [FILE_W-1:0] file,
                                              input logic [TIME_W-1:0] delay,
                                              input logic [TIME_W-1:0] life);
        t_in_item it;
        it.mode        = MODE_REQUEST;
        it.group       = grp;
        it.file_id     = file;
        it.delay_ms    = delay;
        it.lifetime_ms = life;
        it.delta_ms    = TIME_W'($urandom);
        return it;
    endfunction

    // Build a time tick; the request fields carry noise
    function automatic t_in_item make_tick(input logic [TIME_W-1:0] delta);
        t_in_item it;
        it.mode        = MODE_TICK;
        it.group       = GROUP_W'($urandom);
        it.file_id     = FILE_W'($urandom);
        it.delay_ms    = TIME_W'($urandom);
        it.lifetime_ms = TIME_W'($urandom);
        it.delta_ms    = delta;
        return it;
    endfunction

    // Offer one item, with an optional gap first, and hold until it is taken
    task automatic send_item(input t_in_item it);
        if (idle_on && $urandom_range(0, 99) < 12) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
        i_item  <= it;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Field extremes, queue and discard decisions, replays and zero spacing
    task automatic test_directed();
        // tick with no group valid: no result
        send_item(make_tick('0));
        // new group with zero spacing, then idle with nothing pending plays again
        send_item(make_request(4'd0, 8'hFF, 16'd0, 16'd0));
        send_item(make_request(4'd0, 8'h00, 16'd0, 16'hFFFF));
        // max cooldown; a wait equal to the lifetime is discarded, as is zero lifetime
        send_item(make_request(4'd15, 8'h00, 16'hFFFF, 16'hFFFF));
        send_item(make_request(4'd15, 8'hA5, 16'hFFFF, 16'hFFFF));
        send_item(make_request(4'd15, 8'h5A, 16'd100, 16'd0));
        // queue, discard at the boundary, queue again
        send_item(make_request(4'd5, 8'h11, 16'd10, 16'd0));
        send_item(make_request(4'd5, 8'h22, 16'd10, 16'd11));
        send_item(make_request(4'd5, 8'h33, 16'd10, 16'd20));
        send_item(make_request(4'd5, 8'h44, 16'd10, 16'd21));
        // queue three with zero spacing
        send_item(make_request(4'd6, 8'h66, 16'd10, 16'd0));
        repeat (3) send_item(make_request(4'd6, 8'h67, 16'd0, 16'd100));
        // two replays in one tick, ascending order
        send_item(make_tick(16'd10));
        // zero spacing: replay again on a zero-delta tick
        send_item(make_tick(16'd0));
        // idle with pending: spacing update only
        send_item(make_request(4'd6, 8'h68, 16'd7, 16'd100));
        // max delta clamps every cooldown
        send_item(make_tick(16'hFFFF));
    endtask

    // Queue one request in every group, then replay all of them in one tick
    task automatic test_all_groups_replay();
        send_item(make_tick(16'hFFFF));
        for (int g = 0; g < GROUPS; g++) begin
            send_item(make_request(GROUP_W'(g), FILE_W'($urandom), 16'd1, 16'hFFFF));
            send_item(make_request(GROUP_W'(g), FILE_W'($urandom), 16'd1, 16'hFFFF));
        end
        send_item(make_tick(16'hFFFF));
    endtask

    // Fill one group's pending count past saturation, then drain a few
    task automatic test_pending_saturation();
        idle_on = 1'b0;
        send_item(make_tick(16'd1));
        send_item(make_request(4'd9, FILE_W'($urandom), 16'd50000, 16'hFFFF));
        for (int k = 0; k < FILL_ITEMS; k++)
            send_item(make_request(4'd9, FILE_W'($urandom),
                                   ($urandom_range(0, 3) == 0) ? 16'd1 : 16'd0,
                                   TIME_W'($urandom_range(50300, 65535))));
        idle_on = 1'b1;
        send_item(make_tick(16'hFFFF));
        repeat (4) send_item(make_tick(TIME_W'($urandom_range(0, 5))));
    endtask

    // Mixed requests and ticks with random content
    task automatic test_random_traffic();
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] life;
        logic [TIME_W-1:0] delta;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            // hold a long stretch with no gaps
            idle_on = !(k >= 30 && k < 60);
            if ($urandom_range(0, 99) < 70) begin
                delay = ($urandom_range(0, 7) == 0) ? TIME_W'($urandom)
                                                    : TIME_W'($urandom_range(0, 200));
                life  = ($urandom_range(0, 7) == 0) ? TIME_W'($urandom)
                                                    : TIME_W'($urandom_range(0, 2000));
                send_item(make_request(GROUP_W'($urandom), FILE_W'($urandom), delay, life));
            end else begin
                case ($urandom_range(0, 15))
                    0:       delta = '0;
                    1, 2:    delta = TIME_W'($urandom);
                    default: delta = TIME_W'($urandom_range(0, 300));
                endcase
                send_item(make_tick(delta));
            end
        end
    endtask

    initial begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_valid[g]    = 1'b0;
            grp_cooldown[g] = '0;
            grp_spacing[g]  = '0;
            grp_pending[g]  = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_all_groups_replay();
        test_pending_saturation();
        test_random_traffic();

        // drain outstanding plays, then allow the sweep to finish
        i_start <= 1'b0;
        while (expected_plays.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/gthr_pkg.sv
rtl/group_event_throttle.sv
verif/tb.sv
